### design/rhcr_pkg.sv
// Shared types and constants for the region colour-ratio reclassifier.
// Holds the item structs, the sequencer types and the class codes.
// No dependencies.
`timescale 1ns / 1ps

package rhcr_pkg;

    // Item widths
    localparam int HUE_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int CLASS_W = 8;
    localparam int DIM_W   = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SATURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS = 3'd4;

    // Reset values of the registers
    localparam logic              RST_ENABLE         = 1'b1;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH    = 13'd1280;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT   = 13'd720;
    localparam logic [CHAN_W-1:0] RST_MIN_SATURATION = 8'd45;
    localparam logic [CHAN_W-1:0] RST_MIN_BRIGHTNESS = 8'd35;

    // Detector class codes
    localparam logic [CLASS_W-1:0] CLS_APPLE  = 8'd0;
    localparam logic [CLASS_W-1:0] CLS_ORANGE = 8'd2;
    localparam logic [CLASS_W-1:0] CLS_ONION  = 8'd15;
    localparam logic [CLASS_W-1:0] CLS_EGG    = 8'd18;

    localparam int DEF_MAX_REGION_PIXELS = 1048576;

    // Decision sequencer
    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 26;
    localparam int NUM_TESTS = 12;
    localparam int TEST_W    = 4;

    // Test slots in the flag vector
    localparam logic [TEST_W-1:0] T_VALID     = 4'd0;
    localparam logic [TEST_W-1:0] T_RED_SHARE = 4'd1;
    localparam logic [TEST_W-1:0] T_RED_LEAD  = 4'd2;
    localparam logic [TEST_W-1:0] T_APPLE_SAT = 4'd3;
    localparam logic [TEST_W-1:0] T_APPLE_VAL = 4'd4;
    localparam logic [TEST_W-1:0] T_PUR_SHARE = 4'd5;
    localparam logic [TEST_W-1:0] T_PUR_LEAD  = 4'd6;
    localparam logic [TEST_W-1:0] T_ONION_SAT = 4'd7;
    localparam logic [TEST_W-1:0] T_EGG_TONE  = 4'd8;
    localparam logic [TEST_W-1:0] T_EGG_W     = 4'd9;
    localparam logic [TEST_W-1:0] T_EGG_H     = 4'd10;
    localparam logic [TEST_W-1:0] T_EGG_AREA  = 4'd11;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_CALC,
        ST_DONE
    } state_t;

    // What to do with a product once it is registered
    typedef enum logic [1:0] {
        ACT_NONE,   // intermediate of a chained product
        ACT_LHS,    // hold as left-hand side
        ACT_CMP     // compare held left-hand side against it
    } act_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [CHAN_W-1:0]  sat;
        logic [CHAN_W-1:0]  bright;
        logic               last_pixel;
        logic [CLASS_W-1:0] original_class;
        logic [DIM_W-1:0]   box_width;
        logic [DIM_W-1:0]   box_height;
        logic               hand_covered;
    } pixel_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] final_class;
        logic               stats_valid;
        logic               changed;
    } result_item_t;

endpackage

### design/roi_hsv_color_ratio_reclassifier_unit.sv
// Region colour-ratio reclassifier: pixel statistics and per-region decision.
// Counts pixels per region, then runs every ratio test through one shared multiplier.
// Depends on rhcr_pkg.
`timescale 1ns / 1ps

// Throughput: one pixel item per cycle while a region streams in.
// After the last pixel of a region is taken, the decision sequencer runs its steps
//   and the result item is then loaded into the output register, once that is
//   free; the block takes no pixel until the result item is loaded.
// The decision cost is set by the single multiplier (y operand 13 bits wide):
//   26 products issued back to back, then a drain step for the product register.
// Reset: counters, sequencer and output valid clear; registers take their defaults.
module roi_hsv_color_ratio_reclassifier_unit #(
    parameter int MAX_REGION_PIXELS = rhcr_pkg::DEF_MAX_REGION_PIXELS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  rhcr_pkg::pixel_item_t               pixel,

    output logic                                result_valid,
    input  logic                                result_ready,
    output rhcr_pkg::result_item_t              result,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rhcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rhcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Counter, sum, multiplier operand and product widths
    localparam int CW   = $clog2(MAX_REGION_PIXELS + 1);
    localparam int SW   = CW + rhcr_pkg::CHAN_W;
    localparam int XW   = (SW > 2 * rhcr_pkg::DIM_W) ? SW : 2 * rhcr_pkg::DIM_W;
    localparam int YW   = rhcr_pkg::DIM_W;
    localparam int PW   = XW + YW;
    localparam int CMPW = PW + 1;

    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_REGION_PIXELS);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ------------------------------------------------------------------
    logic                          enable_reg;
    logic [rhcr_pkg::DIM_W-1:0]    frame_width_reg;
    logic [rhcr_pkg::DIM_W-1:0]    frame_height_reg;
    logic [rhcr_pkg::CHAN_W-1:0]   min_saturation_reg;
    logic [rhcr_pkg::CHAN_W-1:0]   min_brightness_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= rhcr_pkg::RST_ENABLE;
            frame_width_reg    <= rhcr_pkg::RST_FRAME_WIDTH;
            frame_height_reg   <= rhcr_pkg::RST_FRAME_HEIGHT;
            min_saturation_reg <= rhcr_pkg::RST_MIN_SATURATION;
            min_brightness_reg <= rhcr_pkg::RST_MIN_BRIGHTNESS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rhcr_pkg::CFG_ENABLE:         enable_reg         <= cfg_data[0];
                rhcr_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                rhcr_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                rhcr_pkg::CFG_MIN_SATURATION: min_saturation_reg <= cfg_data[7:0];
                rhcr_pkg::CFG_MIN_BRIGHTNESS: min_brightness_reg <= cfg_data[7:0];
                default:                      ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    rhcr_pkg::state_t state_reg, state_next;
    logic [rhcr_pkg::STEP_W-1:0] step_reg, step_next;
    logic result_valid_reg, result_valid_next;

    logic pixel_take;   // a pixel item is accepted this cycle
    logic calc_run;     // decision sequencer active
    logic result_load;  // move the decision into the output register

    assign pixel_take = pixel_valid && pixel_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rhcr_pkg::ST_ACC:
                if (pixel_take && pixel.last_pixel)
                    state_next = rhcr_pkg::ST_CALC;
            rhcr_pkg::ST_CALC:
                if (step_reg == rhcr_pkg::STEP_W'(rhcr_pkg::LAST_STEP))
                    state_next = rhcr_pkg::ST_DONE;
            rhcr_pkg::ST_DONE:
                if (result_load)
                    state_next = rhcr_pkg::ST_ACC;
            default:
                state_next = rhcr_pkg::ST_ACC;
        endcase
    end

    always_comb
    begin
        pixel_ready = 1'b0;
        calc_run    = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            rhcr_pkg::ST_ACC:  pixel_ready = 1'b1;
            rhcr_pkg::ST_CALC: calc_run    = 1'b1;
            rhcr_pkg::ST_DONE: result_load = !result_valid_reg || result_ready;
            default:           ;
        endcase
    end

    always_comb
    begin
        step_next = '0;
        if (calc_run)
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rhcr_pkg::ST_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel classification and region counters
    // ------------------------------------------------------------------
    logic [CW-1:0] pixel_count_reg, bright_count_reg, red_count_reg;
    logic [CW-1:0] purple_count_reg, egg_tone_count_reg;
    logic [SW-1:0] saturation_sum_reg, value_sum_reg;

    logic px_lit, px_colorful, px_red, px_purple, px_egg_tone, px_count;

    always_comb
    begin
        px_lit      = pixel.bright >= min_brightness_reg;
        px_colorful = px_lit && (pixel.sat >= min_saturation_reg);
        // hue codes above 179 are not folded: anything from 170 up counts as red
        px_red      = px_colorful && (pixel.hue <= 8'd10 || pixel.hue >= 8'd170);
        px_purple   = px_colorful && pixel.hue >= 8'd125 && pixel.hue <= 8'd170;
        px_egg_tone = (pixel.bright >= 8'd55) &&
                      ((pixel.hue >= 8'd4 && pixel.hue <= 8'd55) ||
                       (pixel.sat <= 8'd95 && pixel.bright >= 8'd80));
        // ignore pixels once the region is full; the last one still closes it
        px_count    = pixel_take && (pixel_count_reg < MAX_COUNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg    <= '0;
            bright_count_reg   <= '0;
            red_count_reg      <= '0;
            purple_count_reg   <= '0;
            egg_tone_count_reg <= '0;
            saturation_sum_reg <= '0;
            value_sum_reg      <= '0;
        end
        else if (result_load)
        begin
            pixel_count_reg    <= '0;
            bright_count_reg   <= '0;
            red_count_reg      <= '0;
            purple_count_reg   <= '0;
            egg_tone_count_reg <= '0;
            saturation_sum_reg <= '0;
            value_sum_reg      <= '0;
        end
        else if (px_count)
        begin
            pixel_count_reg <= pixel_count_reg + 1'b1;
            if (px_lit)
            begin
                bright_count_reg   <= bright_count_reg + 1'b1;
                saturation_sum_reg <= saturation_sum_reg + SW'(pixel.sat);
                value_sum_reg      <= value_sum_reg + SW'(pixel.bright);
            end
            if (px_red)
                red_count_reg <= red_count_reg + 1'b1;
            if (px_purple)
                purple_count_reg <= purple_count_reg + 1'b1;
            if (px_egg_tone)
                egg_tone_count_reg <= egg_tone_count_reg + 1'b1;
        end
    end

    // Detection fields, captured with the last pixel
    logic [rhcr_pkg::CLASS_W-1:0] class_reg;
    logic [rhcr_pkg::DIM_W-1:0]   box_width_reg, box_height_reg;
    logic                         hand_reg;

    always_ff @(posedge clk)
    begin
        if (pixel_take && pixel.last_pixel)
        begin
            class_reg      <= pixel.original_class;
            box_width_reg  <= pixel.box_width;
            box_height_reg <= pixel.box_height;
            hand_reg       <= pixel.hand_covered;
        end
    end

    // ------------------------------------------------------------------
    // Decision sequencer. Every threshold is a test lhs >= rhs between two
    // products. Each step issues one product into the shared multiplier;
    // the next cycle holds it plus an offset as lhs, or compares it plus an offset
    // against the held lhs and stores the outcome in a flag, or keeps it for a chain.
    //   valid:     20*bright + 19 >= 11*total  (bright >= floor(11*total/20))
    //   egg area:  65*fw*fh >= 2304*w*h        (the 26000 / 921600 test over 400)
    // ------------------------------------------------------------------
    logic [XW-1:0]               op_x;
    logic [YW-1:0]               op_y;
    rhcr_pkg::act_t              op_act;
    logic [CW-1:0]               op_add;
    logic [rhcr_pkg::TEST_W-1:0] op_test;

    logic [PW-1:0]               prod_reg;
    rhcr_pkg::act_t              act_reg;
    logic [CW-1:0]               add_reg;
    logic [rhcr_pkg::TEST_W-1:0] test_reg;
    logic [CMPW-1:0]             lhs_reg;
    logic [rhcr_pkg::NUM_TESTS-1:0] flags_reg;

    logic [CMPW-1:0]             prod_plus;

    always_comb
    begin
        op_x    = '0;
        op_y    = '0;
        op_act  = rhcr_pkg::ACT_NONE;
        op_add  = '0;
        op_test = rhcr_pkg::T_VALID;
        case (step_reg)
            5'd0:  begin op_x = XW'(bright_count_reg);   op_y = YW'(20);
                         op_act = rhcr_pkg::ACT_LHS; op_add = CW'(19); end
            5'd1:  begin op_x = XW'(pixel_count_reg);    op_y = YW'(11);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_VALID; end
            5'd2:  begin op_x = XW'(red_count_reg);      op_y = YW'(25);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd3:  begin op_x = XW'(pixel_count_reg);    op_y = YW'(6);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_RED_SHARE; end
            5'd4:  begin op_x = XW'(red_count_reg);      op_y = YW'(20);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd5:  begin op_x = XW'(purple_count_reg);   op_y = YW'(20);
                         op_act = rhcr_pkg::ACT_CMP; op_add = pixel_count_reg;
                         op_test = rhcr_pkg::T_RED_LEAD; end
            5'd6:  begin op_x = XW'(saturation_sum_reg); op_y = YW'(1);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd7:  begin op_x = XW'(bright_count_reg);   op_y = YW'(55);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_APPLE_SAT; end
            5'd8:  begin op_x = XW'(value_sum_reg);      op_y = YW'(1);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd9:  begin op_x = XW'(bright_count_reg);   op_y = YW'(65);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_APPLE_VAL; end
            5'd10: begin op_x = XW'(purple_count_reg);   op_y = YW'(5);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd11: begin op_x = XW'(pixel_count_reg);    op_y = YW'(1);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_PUR_SHARE; end
            5'd12: begin op_x = XW'(purple_count_reg);   op_y = YW'(25);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd13: begin op_x = XW'(red_count_reg);      op_y = YW'(25);
                         op_act = rhcr_pkg::ACT_CMP; op_add = pixel_count_reg;
                         op_test = rhcr_pkg::T_PUR_LEAD; end
            5'd14: begin op_x = XW'(saturation_sum_reg); op_y = YW'(1);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd15: begin op_x = XW'(bright_count_reg);   op_y = YW'(45);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_ONION_SAT; end
            5'd16: begin op_x = XW'(egg_tone_count_reg); op_y = YW'(25);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd17: begin op_x = XW'(pixel_count_reg);    op_y = YW'(2);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_EGG_TONE; end
            5'd18: begin op_x = XW'(frame_width_reg);    op_y = YW'(155);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd19: begin op_x = XW'(box_width_reg);      op_y = YW'(1280);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_EGG_W; end
            5'd20: begin op_x = XW'(frame_height_reg);   op_y = YW'(235);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd21: begin op_x = XW'(box_height_reg);     op_y = YW'(720);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_EGG_H; end
            // chained products: feed the registered product back in
            5'd22: begin op_x = XW'(frame_width_reg);    op_y = frame_height_reg; end
            5'd23: begin op_x = prod_reg[XW-1:0];        op_y = YW'(65);
                         op_act = rhcr_pkg::ACT_LHS; end
            5'd24: begin op_x = XW'(box_width_reg);      op_y = box_height_reg; end
            5'd25: begin op_x = prod_reg[XW-1:0];        op_y = YW'(2304);
                         op_act = rhcr_pkg::ACT_CMP; op_test = rhcr_pkg::T_EGG_AREA; end
            default: ;  // drain step: nothing issued
        endcase
    end

    assign prod_plus = CMPW'(prod_reg) + CMPW'(add_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= rhcr_pkg::ACT_NONE;
        else if (calc_run)
            act_reg <= op_act;
        else
            act_reg <= rhcr_pkg::ACT_NONE;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(op_x) * PW'(op_y);
        add_reg  <= op_add;
        test_reg <= op_test;
        if (act_reg == rhcr_pkg::ACT_LHS)
            lhs_reg <= prod_plus;
        if (act_reg == rhcr_pkg::ACT_CMP)
            flags_reg[test_reg] <= (lhs_reg >= prod_plus);
    end

    // ------------------------------------------------------------------
    // Final class from the flags
    // ------------------------------------------------------------------
    logic                         has_bright, frame_ok, stats_ok;
    logic                         is_apple, is_onion, is_egg;
    logic [rhcr_pkg::CLASS_W-1:0] final_class;

    always_comb
    begin
        has_bright = bright_count_reg != '0;
        frame_ok   = (frame_width_reg != '0) && (frame_height_reg != '0);
        stats_ok   = flags_reg[rhcr_pkg::T_VALID];
        is_apple   = flags_reg[rhcr_pkg::T_RED_SHARE] && flags_reg[rhcr_pkg::T_RED_LEAD] &&
                     has_bright && flags_reg[rhcr_pkg::T_APPLE_SAT] &&
                     flags_reg[rhcr_pkg::T_APPLE_VAL];
        is_onion   = flags_reg[rhcr_pkg::T_PUR_SHARE] && flags_reg[rhcr_pkg::T_PUR_LEAD] &&
                     has_bright && flags_reg[rhcr_pkg::T_ONION_SAT];
        is_egg     = flags_reg[rhcr_pkg::T_EGG_TONE] && frame_ok &&
                     flags_reg[rhcr_pkg::T_EGG_W] && flags_reg[rhcr_pkg::T_EGG_H] &&
                     flags_reg[rhcr_pkg::T_EGG_AREA];

        final_class = class_reg;
        if (enable_reg && stats_ok)
        begin
            case (class_reg) inside
                rhcr_pkg::CLS_APPLE, rhcr_pkg::CLS_ONION:
                begin
                    // a covering hand makes the colour untrustworthy: keep the class
                    if (!hand_reg && is_apple && !is_onion)
                        final_class = rhcr_pkg::CLS_APPLE;
                    else if (!hand_reg && is_onion && !is_apple)
                        final_class = rhcr_pkg::CLS_ONION;
                end
                rhcr_pkg::CLS_EGG, rhcr_pkg::CLS_ORANGE:
                    final_class = is_egg ? rhcr_pkg::CLS_EGG : rhcr_pkg::CLS_ORANGE;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the item until taken, pixels may stream meanwhile
    // ------------------------------------------------------------------
    rhcr_pkg::result_item_t result_reg;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.final_class <= final_class;
            result_reg.stats_valid <= stats_ok;
            result_reg.changed     <= final_class != class_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (pixel_count_reg == '0 && bright_count_reg == '0 &&
                         saturation_sum_reg == '0))
        else $error("region counters not cleared after the result item");

    a_bright_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        bright_count_reg <= pixel_count_reg)
        else $error("bright count exceeds pixel count");

    a_red_le_bright: assert property (@(posedge clk) disable iff (!rst_n)
        red_count_reg <= bright_count_reg && purple_count_reg <= bright_count_reg)
        else $error("colour count exceeds bright count");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_count_reg <= MAX_COUNT)
        else $error("pixel count beyond region limit");

    a_no_change_without_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.stats_valid) |-> !result.changed)
        else $error("class changed without enough bright pixels");

    a_no_pixel_while_deciding: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_take && pixel.last_pixel) |=> !pixel_ready)
        else $error("pixel taken while the decision runs");

endmodule
